### rtl/core/implicant_merge_pass_assert.svh
// Assertion macros used by the implicant merge pass top level.
`ifndef IMPLICANT_MERGE_PASS_ASSERT_SVH
`define IMPLICANT_MERGE_PASS_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define IMP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implicant merge pass: same-cycle check failed");
`define IMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("implicant merge pass: next-cycle check failed");
`else
`define IMP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define IMP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/impmerge_pkg.sv
// Types and codes shared by the implicant merge pass modules.
`timescale 1ns / 1ps
package impmerge_pkg;

	localparam int ROW_W   = 16;
	localparam int COUNT_W = 5;
	localparam int IDX_W   = 8;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_FETCH = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [2:0] ST_PAIR      = 3'd0;
	localparam logic [2:0] ST_EXHAUSTED = 3'd1;
	localparam logic [2:0] ST_STORED    = 3'd2;
	localparam logic [2:0] ST_DROPPED   = 3'd3;
	localparam logic [2:0] ST_CLEARED   = 3'd4;

	typedef struct packed {
		logic [1:0]       op;
		logic [ROW_W-1:0] row_value;
		logic [ROW_W-1:0] row_dont_care;
	} in_word_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [ROW_W-1:0] merged_value;
		logic [ROW_W-1:0] merged_dont_care;
		logic [IDX_W-1:0] first_row;
		logic [IDX_W-1:0] second_row;
	} out_word_t;

	typedef struct packed {
		logic [ROW_W-1:0]   value;
		logic [ROW_W-1:0]   dont_care;
		logic [COUNT_W-1:0] true_count;
	} row_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} store_ctl_t;

endpackage

### rtl/core/implicant_merge_pass.sv
// Top level of the implicant merge pass: command decode, scan sequencer and result word.
// A load, clear or exhausted fetch gives its result word in the cycle after start is taken.
// A fetch scans from its cursors, stepping levels and, for each candidate row pair and each
// lower row passed, reading the store and then comparing; busy is high throughout.
// The word follows the hit compare or the issue step past the last level, and start is taken again then.
// Reset clears the row count, cursors and exhausted flag and sets bits_q to 4.
`timescale 1ns / 1ps
`include "implicant_merge_pass_assert.svh"
module implicant_merge_pass #(
	parameter int MAX_ROWS = 256,
	parameter int MAX_VARS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  impmerge_pkg::in_word_t  item,
	output logic                    busy,
	output logic                    done,
	output impmerge_pkg::out_word_t result,
	input  logic                    cfg_we,
	input  logic [4:0]              cfg_wdata
);
	import impmerge_pkg::*;

	localparam int AW   = $clog2(MAX_ROWS);
	localparam int CW   = $clog2(MAX_ROWS + 1);
	localparam int LW   = $clog2(MAX_VARS + 1);
	localparam int CMPW = ((LW > COUNT_W) ? LW : COUNT_W) + 1;
	localparam int VCAP = (MAX_VARS < ROW_W) ? MAX_VARS : ROW_W;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_ISSUE = 2'd1;
	localparam logic [1:0] S_EVAL  = 2'd2;

	logic [1:0]    state_q;
	logic [4:0]    bits_q;
	logic [CW-1:0] row_count_q;
	logic [LW-1:0] level_q;
	logic [CW-1:0] lower_q;
	logic [CW-1:0] upper_q;
	logic          exhausted_q;
	logic          done_q;
	out_word_t     result_q;

	logic [4:0]       n_vars;
	logic [ROW_W-1:0] use_mask;
	logic [ROW_W-1:0] ld_mask;
	logic [ROW_W-1:0] ld_value;
	logic [ROW_W-1:0] diff;
	logic             accept;
	logic             pair_hit;
	logic             row_a_ok;
	store_ctl_t       st_ctl;
	row_t             wr_row;
	row_t             row_a;
	row_t             row_b;
	logic             res_en;
	out_word_t        res_d;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	always_comb begin
		n_vars = bits_q;
		if (n_vars == 5'd0) begin
			n_vars = 5'd1;
		end
		if (n_vars > 5'(VCAP)) begin
			n_vars = 5'(VCAP);
		end
		for (int i = 0; i < ROW_W; i++) begin
			use_mask[i] = (5'(i) < n_vars);
		end
	end

	assign ld_mask  = item.row_dont_care & use_mask;
	assign ld_value = item.row_value & use_mask & ~ld_mask;

	assign wr_row.value      = ld_value;
	assign wr_row.dont_care  = ld_mask;
	assign wr_row.true_count = COUNT_W'($countones(ld_value));

	assign st_ctl.wr_en = accept && (item.op == OP_LOAD)
		&& (row_count_q != CW'(MAX_ROWS));
	assign st_ctl.rd_en = (state_q == S_ISSUE);

	impmerge_row_store #(
		.ROWS(MAX_ROWS)
	) u_store (
		.clk      (clk),
		.ctl      (st_ctl),
		.wr_addr  (row_count_q[AW-1:0]),
		.wr_row   (wr_row),
		.rd_a_addr(lower_q[AW-1:0]),
		.rd_b_addr(upper_q[AW-1:0]),
		.rd_a_row (row_a),
		.rd_b_row (row_b)
	);

	assign diff     = (row_a.value ^ row_b.value) & use_mask & ~row_a.dont_care;
	assign row_a_ok = (CMPW'(row_a.true_count) == CMPW'(level_q))
		&& (upper_q < row_count_q);
	assign pair_hit = (CMPW'(row_b.true_count) == CMPW'(level_q) + CMPW'(1))
		&& (row_a.dont_care == row_b.dont_care) && $onehot(diff);

	always_comb begin
		res_en = 1'b0;
		res_d  = '0;
		if (state_q == S_IDLE && accept) begin
			case (item.op)
				OP_LOAD: begin
					res_en       = 1'b1;
					res_d.status = (row_count_q == CW'(MAX_ROWS)) ? ST_DROPPED : ST_STORED;
				end
				OP_CLEAR: begin
					res_en       = 1'b1;
					res_d.status = ST_CLEARED;
				end
				OP_FETCH: begin
					res_en       = exhausted_q;
					res_d.status = ST_EXHAUSTED;
				end
				default: begin
					res_en = 1'b0;
				end
			endcase
		end else if (state_q == S_ISSUE && level_q >= LW'(MAX_VARS)) begin
			res_en       = 1'b1;
			res_d.status = ST_EXHAUSTED;
		end else if (state_q == S_EVAL && row_a_ok && pair_hit) begin
			res_en                 = 1'b1;
			res_d.status           = ST_PAIR;
			res_d.merged_value     = row_a.value & ~diff;
			res_d.merged_dont_care = row_a.dont_care | diff;
			res_d.first_row        = IDX_W'(lower_q);
			res_d.second_row       = IDX_W'(upper_q);
		end
	end

	always_ff @(posedge clk) begin
		if (res_en) begin
			result_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bits_q      <= 5'd4;
			row_count_q <= '0;
			level_q     <= '0;
			lower_q     <= '0;
			upper_q     <= '0;
			exhausted_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= res_en;
			if (cfg_we) begin
				bits_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (item.op)
							OP_LOAD: begin
								if (st_ctl.wr_en) begin
									row_count_q <= row_count_q + CW'(1);
								end
							end
							OP_CLEAR: begin
								row_count_q <= '0;
								level_q     <= '0;
								lower_q     <= '0;
								upper_q     <= '0;
								exhausted_q <= 1'b0;
							end
							OP_FETCH: begin
								if (!exhausted_q) begin
									state_q <= S_ISSUE;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_ISSUE: begin
					if (level_q >= LW'(MAX_VARS)) begin
						exhausted_q <= 1'b1;
						state_q     <= S_IDLE;
					end else if (lower_q >= row_count_q) begin
						level_q <= level_q + LW'(1);
						lower_q <= '0;
						upper_q <= '0;
					end else begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (!row_a_ok) begin
						lower_q <= lower_q + CW'(1);
						upper_q <= '0;
						state_q <= S_ISSUE;
					end else begin
						upper_q <= upper_q + CW'(1);
						state_q <= pair_hit ? S_IDLE : S_ISSUE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`IMP_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, row_count_q <= CW'(MAX_ROWS))
	`IMP_ASSERT_IMPL(a_eval_in_range, clk, arst_n, state_q == S_EVAL, lower_q < row_count_q)
	`IMP_ASSERT_NEXT(a_exhausted_reply, clk, arst_n,
		accept && item.op == OP_FETCH && exhausted_q,
		done && result.status == ST_EXHAUSTED)
	`IMP_ASSERT_NEXT(a_full_drop, clk, arst_n,
		accept && item.op == OP_LOAD && row_count_q == CW'(MAX_ROWS),
		done && result.status == ST_DROPPED && $stable(row_count_q))
	`IMP_ASSERT_IMPL(a_pair_merge, clk, arst_n, done && result.status == ST_PAIR,
		(result.merged_value & result.merged_dont_care) == '0 && !busy)

endmodule

### rtl/core/impmerge_row_store.sv
// Row store: one write port and two registered read ports.
`timescale 1ns / 1ps
module impmerge_row_store #(
	parameter int ROWS = 256
) (
	input  logic                              clk,
	input  impmerge_pkg::store_ctl_t          ctl,
	input  logic [$clog2(ROWS)-1:0]           wr_addr,
	input  impmerge_pkg::row_t                wr_row,
	input  logic [$clog2(ROWS)-1:0]           rd_a_addr,
	input  logic [$clog2(ROWS)-1:0]           rd_b_addr,
	output impmerge_pkg::row_t                rd_a_row,
	output impmerge_pkg::row_t                rd_b_row
);
	import impmerge_pkg::*;

	row_t mem [ROWS];
	row_t rd_a_q;
	row_t rd_b_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_row;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_a_q <= mem[rd_a_addr];
			rd_b_q <= mem[rd_b_addr];
		end
	end

	assign rd_a_row = rd_a_q;
	assign rd_b_row = rd_b_q;

endmodule

### test/tb.sv
// Self-checking testbench for implicant_merge_pass: a directed word table, then random sessions.
`timescale 1ns / 1ps
module tb;
	import impmerge_pkg::*;

	localparam int TABLE_DEPTH     = 256;
	localparam int VAR_LIMIT       = 16;
	localparam int WATCHDOG_LIMIT  = 600000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int END_CYCLES      = 16;
	localparam int PHASE_WORDS     = 105;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam out_word_t EXP_EXHAUSTED = '{ST_EXHAUSTED, 16'h0, 16'h0, 8'h0, 8'h0};
	localparam out_word_t EXP_STORED    = '{ST_STORED, 16'h0, 16'h0, 8'h0, 8'h0};
	localparam out_word_t EXP_CLEARED   = '{ST_CLEARED, 16'h0, 16'h0, 8'h0, 8'h0};
	localparam out_word_t EXP_NONE      = '0;

	typedef struct packed {
		in_word_t  word;
		logic      typed;
		out_word_t want;
	} dir_row_t;

	localparam int DIR_ROWS = 25;
	localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
		'{'{OP_FETCH, 16'h0000, 16'h0000}, 1'b1, EXP_EXHAUSTED},
		'{'{OP_FETCH, 16'hFFFF, 16'hFFFF}, 1'b1, EXP_EXHAUSTED},
		'{'{OP_UNUSED, 16'hFFFF, 16'hFFFF}, 1'b0, EXP_NONE},
		'{'{OP_CLEAR, 16'h0000, 16'h0000}, 1'b1, EXP_CLEARED},
		'{'{OP_LOAD, 16'hFFFF, 16'h0000}, 1'b1, EXP_STORED},
		'{'{OP_LOAD, 16'h0007, 16'h0000}, 1'b1, EXP_STORED},
		'{'{OP_LOAD, 16'h0000, 16'hFFFF}, 1'b1, EXP_STORED},
		'{'{OP_LOAD, 16'h0003, 16'h0000}, 1'b1, EXP_STORED},
		'{'{OP_LOAD, 16'h0001, 16'h0000}, 1'b1, EXP_STORED},
		'{'{OP_LOAD, 16'h0000, 16'h0000}, 1'b1, EXP_STORED},
		'{'{OP_LOAD, 16'h0009, 16'h0001}, 1'b1, EXP_STORED},
		'{'{OP_LOAD, 16'h000A, 16'h0001}, 1'b1, EXP_STORED},
		'{'{OP_LOAD, 16'h0FF8, 16'hF001}, 1'b1, EXP_STORED},
		'{'{OP_FETCH, 16'h0000, 16'h0000}, 1'b0, EXP_NONE},
		'{'{OP_FETCH, 16'h0000, 16'h0000}, 1'b0, EXP_NONE},
		'{'{OP_FETCH, 16'h0000, 16'h0000}, 1'b0, EXP_NONE},
		'{'{OP_FETCH, 16'h0000, 16'h0000}, 1'b0, EXP_NONE},
		'{'{OP_FETCH, 16'h0000, 16'h0000}, 1'b0, EXP_NONE},
		'{'{OP_FETCH, 16'h0000, 16'h0000}, 1'b0, EXP_NONE},
		'{'{OP_FETCH, 16'h0000, 16'h0000}, 1'b0, EXP_NONE},
		'{'{OP_FETCH, 16'h0000, 16'h0000}, 1'b1, EXP_EXHAUSTED},
		'{'{OP_FETCH, 16'h0000, 16'h0000}, 1'b1, EXP_EXHAUSTED},
		'{'{OP_LOAD, 16'h0001, 16'h0000}, 1'b1, EXP_STORED},
		'{'{OP_FETCH, 16'h0000, 16'h0000}, 1'b1, EXP_EXHAUSTED},
		'{'{OP_CLEAR, 16'h0000, 16'h0000}, 1'b1, EXP_CLEARED}
	};

	logic      clk;
	logic      arst_n;
	logic      start;
	in_word_t  item;
	logic      busy;
	logic      done;
	out_word_t result;
	logic      cfg_we;
	logic [4:0] cfg_wdata;

	implicant_merge_pass #(
		.MAX_ROWS(TABLE_DEPTH),
		.MAX_VARS(VAR_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Shadow copy of the row table, scan cursors and variable count.
	logic [ROW_W-1:0]   tbl_val  [TABLE_DEPTH];
	logic [ROW_W-1:0]   tbl_mask [TABLE_DEPTH];
	logic [COUNT_W-1:0] tbl_ones [TABLE_DEPTH];
	int unsigned n_rows = 0;
	int unsigned lvl = 0;
	int unsigned lo = 0;
	int unsigned hi = 0;
	bit pass_done = 0;
	logic [4:0] var_count = 5'd4;

	out_word_t pending_words[$];
	out_word_t given_want;
	logic      given_typed;
	int        fail_count = 0;
	int        idle_cycles = 0;
	int        words_sent = 0;
	int        idle_pct = 0;
	logic [4:0] bits_now = 5'd4;

	function automatic bit table_step(input in_word_t w, output out_word_t r);
		logic [ROW_W-1:0] use_bits;
		logic [ROW_W-1:0] m;
		logic [ROW_W-1:0] v;
		logic [ROW_W-1:0] diff;
		int unsigned n;
		int unsigned a;
		int unsigned b;
		r = '0;
		n = {27'd0, var_count};
		if (n < 1) n = 1;
		if (n > 16) n = 16;
		if (n > VAR_LIMIT) n = VAR_LIMIT;
		use_bits = (n >= 16) ? 16'hFFFF : ROW_W'((32'd1 << n) - 1);
		case (w.op)
			OP_LOAD: begin
				m = w.row_dont_care & use_bits;
				v = w.row_value & use_bits & ~m;
				if (n_rows >= TABLE_DEPTH) begin
					r.status = ST_DROPPED;
					return 1'b1;
				end
				tbl_val[n_rows] = v;
				tbl_mask[n_rows] = m;
				tbl_ones[n_rows] = COUNT_W'($countones(v));
				n_rows++;
				r.status = ST_STORED;
				return 1'b1;
			end
			OP_CLEAR: begin
				n_rows = 0;
				lvl = 0;
				lo = 0;
				hi = 0;
				pass_done = 0;
				r.status = ST_CLEARED;
				return 1'b1;
			end
			OP_FETCH: begin
				while (!pass_done) begin
					if (lvl >= VAR_LIMIT) begin
						pass_done = 1;
						break;
					end
					if (lo >= n_rows || lo >= TABLE_DEPTH) begin
						lvl++;
						lo = 0;
						hi = 0;
						continue;
					end
					if (tbl_ones[lo] != lvl || hi >= n_rows || hi >= TABLE_DEPTH) begin
						lo++;
						hi = 0;
						continue;
					end
					a = lo;
					b = hi;
					hi++;
					if (tbl_ones[b] == lvl + 1 && tbl_mask[a] == tbl_mask[b]) begin
						diff = (tbl_val[a] ^ tbl_val[b]) & use_bits & ~tbl_mask[a];
						if ($countones(diff) == 1) begin
							r.status = ST_PAIR;
							r.merged_value = tbl_val[a] & ~diff;
							r.merged_dont_care = tbl_mask[a] | diff;
							r.first_row = a[IDX_W-1:0];
							r.second_row = b[IDX_W-1:0];
							return 1'b1;
						end
					end
				end
				r.status = ST_EXHAUSTED;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		out_word_t want;
		out_word_t pred;
		bit has_word;
		if (arst_n) begin
			if (done) begin
				if (pending_words.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result word: status %0d value %h dc %h rows %0d/%0d",
							result.status, result.merged_value, result.merged_dont_care,
							result.first_row, result.second_row);
					fail_count++;
				end else begin
					want = pending_words.pop_front();
					if (result.status !== want.status ||
						result.merged_value !== want.merged_value ||
						result.merged_dont_care !== want.merged_dont_care ||
						result.first_row !== want.first_row ||
						result.second_row !== want.second_row) begin
						if (fail_count < 10) begin
							$display("mismatch expected: status %0d value %h dc %h rows %0d/%0d",
								want.status, want.merged_value, want.merged_dont_care,
								want.first_row, want.second_row);
							$display("mismatch actual:   status %0d value %h dc %h rows %0d/%0d",
								result.status, result.merged_value, result.merged_dont_care,
								result.first_row, result.second_row);
						end
						fail_count++;
					end
				end
			end
			if (cfg_we)
				var_count = cfg_wdata;
			if (start && !busy) begin
				has_word = table_step(item, pred);
				if (has_word)
					pending_words.push_back(given_typed ? given_want : pred);
			end
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("implicant_merge_pass verification failed");
				$finish;
			end
		end
	end

	function automatic in_word_t make_word(input logic [1:0] op, input logic [15:0] v,
		input logic [15:0] dc);
		in_word_t w;
		w.op = op;
		w.row_value = v;
		w.row_dont_care = dc;
		return w;
	endfunction

	task automatic send_word(input in_word_t w, input logic typed = 1'b0,
		input out_word_t want = '0);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item <= w;
		given_typed <= typed;
		given_want <= want;
		do @(posedge clk); while (busy);
		if (w.op != OP_UNUSED)
			words_sent++;
	endtask

	task automatic wait_quiet();
		@(negedge clk);
		start <= 1'b0;
		while (pending_words.size() != 0 || busy) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_bits(input logic [4:0] v);
		wait_quiet();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		bits_now = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Fills the table to its last row so the top indices and the dropped load are reached.
	task automatic fill_table_run();
		send_word(make_word(OP_CLEAR, 16'($urandom), 16'($urandom)));
		repeat (TABLE_DEPTH - 2) send_word(make_word(OP_LOAD, 16'hFFFF, 16'h0000));
		send_word(make_word(OP_LOAD, 16'h0000, 16'h0000));
		send_word(make_word(OP_LOAD, 16'h0001, 16'h0000));
		send_word(make_word(OP_LOAD, 16'($urandom), 16'($urandom)));
		send_word(make_word(OP_FETCH, 16'($urandom), 16'($urandom)));
		send_word(make_word(OP_FETCH, 16'($urandom), 16'($urandom)));
		send_word(make_word(OP_CLEAR, 16'($urandom), 16'($urandom)));
	endtask

	// Loads a family of rows that mostly differ by one bit, then walks the pass.
	task automatic run_session();
		int k;
		int pick;
		int span;
		logic [15:0] care_mask;
		logic [15:0] v;
		logic [15:0] dc;
		logic [15:0] seen[$];
		span = (bits_now == 0) ? 1 : ((bits_now > 16) ? 16 : int'(bits_now));
		if (n_rows > 40 || $urandom_range(99) < 80)
			send_word(make_word(OP_CLEAR, 16'($urandom), 16'($urandom)));
		k = $urandom_range(16, 2);
		care_mask = 16'($urandom & $urandom);
		for (int i = 0; i < k; i++) begin
			pick = $urandom_range(99);
			if (pick < 65 && seen.size() > 0)
				v = seen[$urandom_range(seen.size() - 1)] ^
					(16'h1 << ((pick < 8) ? $urandom_range(15) : $urandom_range(span - 1)));
			else
				v = 16'($urandom);
			dc = (pick >= 85) ? 16'($urandom) : care_mask;
			seen.push_back(v);
			send_word(make_word(OP_LOAD, v, dc));
		end
		repeat ($urandom_range(3 * k, k)) begin
			pick = $urandom_range(99);
			if (pick < 5)
				send_word(make_word(OP_LOAD, 16'($urandom), 16'($urandom & $urandom)));
			else if (pick < 8)
				send_word(make_word(OP_UNUSED, 16'($urandom), 16'($urandom)));
			else if (pick < 9)
				send_word(make_word(OP_CLEAR, 16'($urandom), 16'($urandom)));
			else begin
				if (pick < 12)
					wait_quiet();
				send_word(make_word(OP_FETCH, 16'($urandom), 16'($urandom)));
			end
		end
	endtask

	initial begin
		logic [4:0] phase_bits [8];
		int idle_plan [4];
		int phase_start;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		given_typed = 1'b0;
		given_want = '0;
		phase_bits = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2, 5'd8, 5'($urandom_range(31))};
		idle_plan = '{0, 61, 0, 14};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		idle_pct = 14;
		for (int i = 0; i < DIR_ROWS; i++)
			send_word(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].want);

		for (int p = 0; p < 8; p++) begin
			idle_pct = idle_plan[p % 4];
			write_bits(phase_bits[p]);
			if (p == 1)
				fill_table_run();
			phase_start = words_sent;
			while (words_sent - phase_start < PHASE_WORDS)
				run_session();
		end

		wait_quiet();
		repeat (END_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_words.size() == 0)
			$display("implicant_merge_pass verification clean");
		else
			$display("implicant_merge_pass verification failed");
		$finish;
	end

endmodule
